// File: design/wcpb_pkg.sv
`default_nettype none

package wcpb_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned MAX_WORDS   = 8;
  localparam int unsigned LED_W       = 7;

  typedef logic [4:0] word_t;

  localparam word_t W_NONE        = 5'd0;
  localparam word_t W_EINS        = 5'd1;
  localparam word_t W_ZWOELF      = 5'd12;
  localparam word_t W_EIN         = 5'd13;
  localparam word_t W_ZWANZIG     = 5'd14;
  localparam word_t W_VOR         = 5'd15;
  localparam word_t W_NACH        = 5'd16;
  localparam word_t W_UM          = 5'd17;
  localparam word_t W_VIERTEL     = 5'd18;
  localparam word_t W_HALB        = 5'd19;
  localparam word_t W_DREIVIERTEL = 5'd20;
  localparam word_t W_FUENF_M     = 5'd21;
  localparam word_t W_ZEHN_M      = 5'd22;
  localparam word_t W_ES          = 5'd23;
  localparam word_t W_IST         = 5'd24;
  localparam word_t W_ETWA        = 5'd25;
  localparam word_t W_GENAU       = 5'd26;
  localparam word_t W_UHR         = 5'd27;

  typedef enum logic [1:0] {
    CFG_DIALECT   = 2'd0,
    CFG_PRECISION = 2'd1,
    CFG_TRAILER   = 2'd2
  } cfg_idx_e;

  localparam logic [1:0] PREC_GENAU = 2'b01;
  localparam logic [1:0] PREC_ETWA  = 2'b10;

  typedef struct packed {
    word_t [MAX_WORDS-1:0] words;
    logic [$clog2(MAX_WORDS)-1:0] last_idx;
  } phrase_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    word_t w0;
    word_t w1;
    word_t w2;
    logic  next_hour;
  } slot_row_t;

  typedef struct packed {
    logic [LED_W-1:0] first_led;
    logic [LED_W-1:0] final_led;
  } led_span_t;

  function automatic slot_row_t slot_row(input logic dialect, input logic [3:0] slot);
    slot_row_t r;
    r = '{W_NONE, W_NONE, W_NONE, 1'b0};
    case ({dialect, slot})
      5'h00: r = '{W_NONE,    W_NONE, W_UM,          1'b0};
      5'h01: r = '{W_FUENF_M, W_NACH, W_NONE,        1'b0};
      5'h02: r = '{W_ZEHN_M,  W_NACH, W_NONE,        1'b0};
      5'h03: r = '{W_NONE,    W_NONE, W_VIERTEL,     1'b1};
      5'h04: r = '{W_ZEHN_M,  W_VOR,  W_HALB,        1'b1};
      5'h05: r = '{W_FUENF_M, W_VOR,  W_HALB,        1'b1};
      5'h06: r = '{W_NONE,    W_NONE, W_HALB,        1'b1};
      5'h07: r = '{W_FUENF_M, W_NACH, W_HALB,        1'b1};
      5'h08: r = '{W_ZEHN_M,  W_NACH, W_HALB,        1'b1};
      5'h09: r = '{W_NONE,    W_NONE, W_DREIVIERTEL, 1'b1};
      5'h0a: r = '{W_ZEHN_M,  W_VOR,  W_NONE,        1'b1};
      5'h0b: r = '{W_FUENF_M, W_VOR,  W_NONE,        1'b1};
      5'h10: r = '{W_NONE,    W_NONE, W_UM,          1'b0};
      5'h11: r = '{W_FUENF_M, W_NACH, W_NONE,        1'b0};
      5'h12: r = '{W_ZEHN_M,  W_NACH, W_NONE,        1'b0};
      5'h13: r = '{W_VIERTEL, W_NACH, W_NONE,        1'b0};
      5'h14: r = '{W_ZWANZIG, W_NACH, W_NONE,        1'b0};
      5'h15: r = '{W_FUENF_M, W_VOR,  W_HALB,        1'b1};
      5'h16: r = '{W_NONE,    W_NONE, W_HALB,        1'b1};
      5'h17: r = '{W_FUENF_M, W_NACH, W_HALB,        1'b1};
      5'h18: r = '{W_ZWANZIG, W_VOR,  W_NONE,        1'b1};
      5'h19: r = '{W_VIERTEL, W_VOR,  W_NONE,        1'b1};
      5'h1a: r = '{W_ZEHN_M,  W_VOR,  W_NONE,        1'b1};
      5'h1b: r = '{W_FUENF_M, W_VOR,  W_NONE,        1'b1};
      default: r = '{W_NONE, W_NONE, W_NONE, 1'b0};
    endcase
    return r;
  endfunction

  function automatic led_span_t led_span(input word_t w);
    led_span_t s;
    s = '{7'd0, 7'd0};
    case (w)
      W_EINS:        s = '{7'd46,  7'd49};
      5'd2:          s = '{7'd44,  7'd47};
      5'd3:          s = '{7'd39,  7'd42};
      5'd4:          s = '{7'd29,  7'd32};
      5'd5:          s = '{7'd33,  7'd36};
      5'd6:          s = '{7'd1,   7'd5};
      5'd7:          s = '{7'd49,  7'd54};
      5'd8:          s = '{7'd17,  7'd20};
      5'd9:          s = '{7'd25,  7'd28};
      5'd10:         s = '{7'd13,  7'd16};
      5'd11:         s = '{7'd22,  7'd24};
      W_ZWOELF:      s = '{7'd56,  7'd60};
      W_EIN:         s = '{7'd46,  7'd48};
      W_ZWANZIG:     s = '{7'd92,  7'd98};
      W_VOR:         s = '{7'd72,  7'd74};
      W_NACH:        s = '{7'd68,  7'd71};
      W_UM:          s = '{7'd75,  7'd76};
      W_VIERTEL:     s = '{7'd77,  7'd83};
      W_HALB:        s = '{7'd62,  7'd65};
      W_DREIVIERTEL: s = '{7'd77,  7'd87};
      W_FUENF_M:     s = '{7'd99,  7'd102};
      W_ZEHN_M:      s = '{7'd88,  7'd91};
      W_ES:          s = '{7'd110, 7'd111};
      W_IST:         s = '{7'd113, 7'd115};
      W_ETWA:        s = '{7'd117, 7'd120};
      W_GENAU:       s = '{7'd104, 7'd108};
      W_UHR:         s = '{7'd8,   7'd10};
      default:       s = '{7'd0, 7'd0};
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// File: design/wcpb_front.sv
`default_nettype none

module wcpb_front import wcpb_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [1:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  input  wire logic [4:0] hours_i,
  input  wire logic [5:0] minutes_i,
  input  wire logic [5:0] seconds_i,
  input  wire q_stat_t    q_stat_i,
  output logic            push_o,
  output phrase_t         phrase_o
);

  logic       dialect_q;
  logic [1:0] prec_q;
  logic       trailer_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dialect_q <= 1'b0;
      prec_q    <= 2'b00;
      trailer_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DIALECT:   dialect_q <= cfg_wdata_i[0];
        CFG_PRECISION: prec_q    <= cfg_wdata_i;
        CFG_TRAILER:   trailer_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign push_o = in_valid_i && !q_stat_i.full;

  // round forward 150 s: carry is 2 min, or 3 min from second 30 on
  logic [6:0]  min_sum;
  logic        hr_carry;
  logic [5:0]  mm;
  logic [5:0]  hr_sum;
  logic [4:0]  mh;
  logic [9:0]  mm_x13;
  logic [3:0]  slot;
  logic [9:0]  raw_x13;
  logic [3:0]  raw_q5;
  logic [5:0]  raw_q5x5;
  logic        exact;
  slot_row_t   row;
  logic [4:0]  hv;
  logic [3:0]  h12;
  logic [3:0]  hour;

  always_comb begin
    min_sum  = {1'b0, minutes_i} + ((seconds_i >= 6'd30) ? 7'd3 : 7'd2);
    hr_carry = (min_sum >= 7'd60);
    mm       = hr_carry ? 6'(min_sum - 7'd60) : min_sum[5:0];
    hr_sum   = {1'b0, hours_i} + {5'd0, hr_carry};
    mh       = (hr_sum >= 6'd24) ? 5'(hr_sum - 6'd24) : hr_sum[4:0];
    mm_x13   = {4'd0, mm} * 10'd13;
    slot     = mm_x13[9:6];
    raw_x13  = {4'd0, minutes_i} * 10'd13;
    raw_q5   = raw_x13[9:6];
    raw_q5x5 = {2'b00, raw_q5} * 6'd5;
    exact    = (raw_q5x5 == minutes_i);
    row      = slot_row(dialect_q, slot);
    hv       = mh + {4'd0, row.next_hour};
    if (hv >= 5'd24) begin
      h12 = 4'(hv - 5'd24);
    end else if (hv >= 5'd12) begin
      h12 = 4'(hv - 5'd12);
    end else begin
      h12 = hv[3:0];
    end
    hour = (h12 == 4'd0) ? 4'd12 : h12;
  end

  logic [3:0] n;
  word_t [MAX_WORDS-1:0] words;

  always_comb begin
    words = '0;
    n     = 4'd0;
    words[n[2:0]] = W_ES;
    n = n + 4'd1;
    words[n[2:0]] = W_IST;
    n = n + 4'd1;
    if (!exact && (prec_q & PREC_ETWA) != 2'b00) begin
      words[n[2:0]] = W_ETWA;
      n = n + 4'd1;
    end else if (exact && (prec_q & PREC_GENAU) != 2'b00) begin
      words[n[2:0]] = W_GENAU;
      n = n + 4'd1;
    end
    if (row.w0 != W_NONE) begin
      words[n[2:0]] = row.w0;
      n = n + 4'd1;
    end
    if (row.w1 != W_NONE) begin
      words[n[2:0]] = row.w1;
      n = n + 4'd1;
    end
    if (row.w2 != W_NONE) begin
      words[n[2:0]] = row.w2;
      n = n + 4'd1;
    end
    if (hour == 4'd1) begin
      words[n[2:0]] = trailer_q ? W_EIN : W_EINS;
    end else begin
      words[n[2:0]] = {1'b0, hour};
    end
    if (trailer_q) begin
      n = n + 4'd1;
      words[n[2:0]] = W_UHR;
    end
    phrase_o.words    = words;
    phrase_o.last_idx = n[2:0];
  end

endmodule

`default_nettype wire

// File: design/wcpb_queue.sv
`default_nettype none

module wcpb_queue import wcpb_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire phrase_t push_data_i,
  input  wire logic    pop_i,
  output phrase_t      head_o,
  output q_stat_t      stat_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);

  phrase_t [Depth-1:0] ent_q;
  phrase_t [Depth-1:0] ent_d;
  logic [CntW-1:0]     cnt_q;
  logic [CntW-1:0]     cnt_d;
  logic [CntW-1:0]     wr_idx;
  logic                push;
  logic                pop;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = ent_q[0];

  assign push   = push_i && !stat_o.full;
  assign pop    = pop_i && !stat_o.empty;
  assign wr_idx = pop ? cnt_q - CntW'(1) : cnt_q;
  assign cnt_d  = cnt_q + CntW'(push) - CntW'(pop);

  // head stays at slot 0; a pop shifts the rest down
  always_comb begin
    for (int i = 0; i < int'(Depth); i++) begin
      ent_d[i] = ent_q[i];
    end
    if (pop) begin
      for (int i = 0; i < int'(Depth) - 1; i++) begin
        ent_d[i] = ent_q[i+1];
      end
    end
    if (push) begin
      for (int i = 0; i < int'(Depth); i++) begin
        if (CntW'(i) == wr_idx) begin
          ent_d[i] = push_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

`default_nettype wire

// File: design/wcpb_back.sv
`default_nettype none

module wcpb_back import wcpb_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire phrase_t    head_i,
  input  wire q_stat_t    q_stat_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [4:0]      word_code_o,
  output logic [6:0]      first_led_o,
  output logic [6:0]      final_led_o,
  output logic            last_word_o
);

  localparam int unsigned IdxW = $clog2(MAX_WORDS);

  logic [IdxW-1:0] idx_q;
  logic            out_valid_q;
  word_t           code_q;
  logic [6:0]      first_q;
  logic [6:0]      final_q;
  logic            last_q;

  logic      fire;
  logic      is_last;
  word_t     cur;
  led_span_t span;

  assign fire    = !q_stat_i.empty && (!out_valid_q || !out_stall_i);
  assign is_last = (idx_q == head_i.last_idx);
  assign cur     = head_i.words[idx_q];
  assign span    = led_span(cur);
  assign pop_o   = fire && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (fire) begin
        out_valid_q <= 1'b1;
        idx_q       <= is_last ? '0 : idx_q + IdxW'(1);
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      code_q  <= cur;
      first_q <= span.first_led;
      final_q <= span.final_led;
      last_q  <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign word_code_o = code_q;
  assign first_led_o = first_q;
  assign final_led_o = final_q;
  assign last_word_o = last_q;

endmodule

`default_nettype wire

// File: design/word_clock_phrase_builder.sv
// Word clock phrase builder: each accepted time beat (hours, minutes, seconds) is
// rounded ahead by 150 s and turned into 4 to 8 word beats (ES IST [ETWA|GENAU]
// minute words, hour word [UHR]) with their LED ranges; last_word_o marks the end.
// The front classifies a time in the cycle it is accepted and writes the whole
// phrase into a QueueDepth-entry queue; while the queue holds a phrase and
// out_stall_i does not hold the output, the back reads one word per cycle from
// the queue head into the output register. in_stall_o is high only while the
// queue is full. Configuration writes must be made while no phrase is pending.
`default_nettype none

module word_clock_phrase_builder import wcpb_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [1:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [4:0] hours_i,
  input  wire logic [5:0] minutes_i,
  input  wire logic [5:0] seconds_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [4:0]      word_code_o,
  output logic [6:0]      first_led_o,
  output logic [6:0]      final_led_o,
  output logic            last_word_o
);

  q_stat_t q_stat;
  phrase_t push_data;
  phrase_t head;
  logic    push;
  logic    pop;

  assign in_stall_o = q_stat.full;

  wcpb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .hours_i     (hours_i),
    .minutes_i   (minutes_i),
    .seconds_i   (seconds_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .phrase_o    (push_data)
  );

  wcpb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  wcpb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .word_code_o (word_code_o),
    .first_led_o (first_led_o),
    .final_led_o (final_led_o),
    .last_word_o (last_word_o)
  );

  a_queue_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty");

  a_led_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (final_led_o >= first_led_o) && (word_code_o != W_NONE))
    else $error("bad word beat");

  a_last_is_hour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_word_o |-> (word_code_o <= W_EIN) || (word_code_o == W_UHR))
    else $error("phrase ends on a non-hour word");

  a_pop_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_valid_o && last_word_o)
    else $error("phrase retired without a last word");

endmodule

`default_nettype wire

// File: tb/word_clock_phrase_builder_test.sv
`timescale 1ns / 100ps

module word_clock_phrase_builder_test import wcpb_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [1:0] CFG_SPARE_IDX = 2'd3;

  typedef struct packed {
    word_t      code;
    logic [6:0] first_led;
    logic [6:0] final_led;
    logic       last_word;
  } word_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = 2'd0;
  logic [1:0] cfg_wdata_i = 2'd0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [4:0] hours_i = 5'd0;
  logic [5:0] minutes_i = 6'd0;
  logic [5:0] seconds_i = 6'd0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [4:0] word_code_o;
  logic [6:0] first_led_o;
  logic [6:0] final_led_o;
  logic       last_word_o;

  // shadow of the block's registers
  logic       dialect_sel = 1'b0;
  logic [1:0] precision_sel = 2'd0;
  logic       uhr_sel = 1'b0;

  word_beat_t  pending_words[$];
  word_beat_t  expected_beat;
  int unsigned send_idle_pct = 7;
  int unsigned stall_pct = 79;
  int unsigned mismatches = 0;
  int unsigned words_checked = 0;
  int unsigned times_sent = 0;
  int unsigned settings_used = 0;
  int unsigned cycles = 0;

  word_clock_phrase_builder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .hours_i    (hours_i),
    .minutes_i  (minutes_i),
    .seconds_i  (seconds_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .word_code_o(word_code_o),
    .first_led_o(first_led_o),
    .final_led_o(final_led_o),
    .last_word_o(last_word_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still pending", cycles,
               pending_words.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Expected word beats for one time of day, appended to pending_words.
  function automatic void build_phrase(input logic [4:0] h, input logic [5:0] m,
                                       input logic [5:0] s);
    int unsigned hh;
    int unsigned mm;
    int unsigned ss;
    int unsigned secs;
    int unsigned slot;
    int unsigned hr;
    logic        ahead;
    word_t       phrase[$];
    word_beat_t  beat;
    hh = h;
    mm = m;
    ss = s;
    secs = (hh * 3600 + mm * 60 + ss + 150) % 86400;
    slot = ((secs / 60) % 60) / 5;
    ahead = (slot >= 3);
    phrase.push_back(W_ES);
    phrase.push_back(W_IST);
    if (mm % 5 != 0) begin
      if ((precision_sel & PREC_ETWA) != 0) phrase.push_back(W_ETWA);
    end else if ((precision_sel & PREC_GENAU) != 0) begin
      phrase.push_back(W_GENAU);
    end
    case (slot)
      0: phrase.push_back(W_UM);
      1: begin phrase.push_back(W_FUENF_M); phrase.push_back(W_NACH); end
      2: begin phrase.push_back(W_ZEHN_M); phrase.push_back(W_NACH); end
      3: begin
        phrase.push_back(W_VIERTEL);
        if (dialect_sel) begin
          phrase.push_back(W_NACH);
          ahead = 1'b0;
        end
      end
      4: begin
        if (dialect_sel) begin
          phrase.push_back(W_ZWANZIG);
          phrase.push_back(W_NACH);
          ahead = 1'b0;
        end else begin
          phrase.push_back(W_ZEHN_M);
          phrase.push_back(W_VOR);
          phrase.push_back(W_HALB);
        end
      end
      5: begin
        phrase.push_back(W_FUENF_M);
        phrase.push_back(W_VOR);
        phrase.push_back(W_HALB);
      end
      6: phrase.push_back(W_HALB);
      7: begin
        phrase.push_back(W_FUENF_M);
        phrase.push_back(W_NACH);
        phrase.push_back(W_HALB);
      end
      8: begin
        if (dialect_sel) begin
          phrase.push_back(W_ZWANZIG);
          phrase.push_back(W_VOR);
        end else begin
          phrase.push_back(W_ZEHN_M);
          phrase.push_back(W_NACH);
          phrase.push_back(W_HALB);
        end
      end
      9: begin
        if (dialect_sel) begin
          phrase.push_back(W_VIERTEL);
          phrase.push_back(W_VOR);
        end else begin
          phrase.push_back(W_DREIVIERTEL);
        end
      end
      10: begin phrase.push_back(W_ZEHN_M); phrase.push_back(W_VOR); end
      default: begin phrase.push_back(W_FUENF_M); phrase.push_back(W_VOR); end
    endcase
    hr = (secs / 3600 + ahead) % 12;
    if (hr == 0) hr = 12;
    if (hr == 1) phrase.push_back(uhr_sel ? W_EIN : W_EINS);
    else phrase.push_back(word_t'(hr));
    if (uhr_sel) phrase.push_back(W_UHR);

    foreach (phrase[i]) begin
      beat.code = phrase[i];
      case (phrase[i])
        W_EIN:         {beat.first_led, beat.final_led} = {7'd46, 7'd48};
        W_ZWANZIG:     {beat.first_led, beat.final_led} = {7'd92, 7'd98};
        W_VOR:         {beat.first_led, beat.final_led} = {7'd72, 7'd74};
        W_NACH:        {beat.first_led, beat.final_led} = {7'd68, 7'd71};
        W_UM:          {beat.first_led, beat.final_led} = {7'd75, 7'd76};
        W_VIERTEL:     {beat.first_led, beat.final_led} = {7'd77, 7'd83};
        W_HALB:        {beat.first_led, beat.final_led} = {7'd62, 7'd65};
        W_DREIVIERTEL: {beat.first_led, beat.final_led} = {7'd77, 7'd87};
        W_FUENF_M:     {beat.first_led, beat.final_led} = {7'd99, 7'd102};
        W_ZEHN_M:      {beat.first_led, beat.final_led} = {7'd88, 7'd91};
        W_ES:          {beat.first_led, beat.final_led} = {7'd110, 7'd111};
        W_IST:         {beat.first_led, beat.final_led} = {7'd113, 7'd115};
        W_ETWA:        {beat.first_led, beat.final_led} = {7'd117, 7'd120};
        W_GENAU:       {beat.first_led, beat.final_led} = {7'd104, 7'd108};
        W_UHR:         {beat.first_led, beat.final_led} = {7'd8, 7'd10};
        default: begin
          // hour words, by hour number
          case (int'(phrase[i]))
            1:  {beat.first_led, beat.final_led} = {7'd46, 7'd49};
            2:  {beat.first_led, beat.final_led} = {7'd44, 7'd47};
            3:  {beat.first_led, beat.final_led} = {7'd39, 7'd42};
            4:  {beat.first_led, beat.final_led} = {7'd29, 7'd32};
            5:  {beat.first_led, beat.final_led} = {7'd33, 7'd36};
            6:  {beat.first_led, beat.final_led} = {7'd1, 7'd5};
            7:  {beat.first_led, beat.final_led} = {7'd49, 7'd54};
            8:  {beat.first_led, beat.final_led} = {7'd17, 7'd20};
            9:  {beat.first_led, beat.final_led} = {7'd25, 7'd28};
            10: {beat.first_led, beat.final_led} = {7'd13, 7'd16};
            11: {beat.first_led, beat.final_led} = {7'd22, 7'd24};
            default: {beat.first_led, beat.final_led} = {7'd56, 7'd60};
          endcase
        end
      endcase
      beat.last_word = (i == phrase.size() - 1);
      pending_words.push_back(beat);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("word %0d arrived with no phrase pending", word_code_o));
      end else begin
        expected_beat = pending_words.pop_front();
        words_checked++;
        if (word_code_o !== expected_beat.code)
          report_mismatch($sformatf("word_code: expected %0d, got %0d",
                                    expected_beat.code, word_code_o));
        if (first_led_o !== expected_beat.first_led)
          report_mismatch($sformatf("first_led of word %0d: expected %0d, got %0d",
                                    expected_beat.code, expected_beat.first_led, first_led_o));
        if (final_led_o !== expected_beat.final_led)
          report_mismatch($sformatf("final_led of word %0d: expected %0d, got %0d",
                                    expected_beat.code, expected_beat.final_led, final_led_o));
        if (last_word_o !== expected_beat.last_word)
          report_mismatch($sformatf("last_word of word %0d: expected %0b, got %0b",
                                    expected_beat.code, expected_beat.last_word, last_word_o));
      end
    end
  end

  task automatic send_time(input logic [4:0] h, input logic [5:0] m, input logic [5:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    hours_i <= h;
    minutes_i <= m;
    seconds_i <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    build_phrase(h, m, s);
    times_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Only called once the block is idle. Bits above a register's width carry junk.
  task automatic apply_config(input logic dialect, input logic [1:0] prec, input logic uhr);
    logic spare;
    spare = 1'($urandom_range(1));
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_DIALECT;
    cfg_wdata_i <= {spare, dialect};
    @(posedge clk_i);
    dialect_sel = dialect;
    cfg_index_i <= CFG_PRECISION;
    cfg_wdata_i <= prec;
    @(posedge clk_i);
    precision_sel = prec;
    cfg_index_i <= CFG_TRAILER;
    cfg_wdata_i <= {~spare, uhr};
    @(posedge clk_i);
    uhr_sel = uhr;
    if ($urandom_range(1)) begin
      // unmapped index, must be ignored
      cfg_index_i <= CFG_SPARE_IDX;
      cfg_wdata_i <= 2'($urandom_range(3));
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic test_directed();
    apply_config(1'b0, 2'd0, 1'b0);
    send_time(5'd0, 6'd0, 6'd0);
    send_time(5'd12, 6'd59, 6'd59);
    send_time(5'd31, 6'd63, 6'd63);
    wait_idle();
    apply_config(1'b1, 2'd3, 1'b1);
    send_time(5'd0, 6'd57, 6'd30);
    send_time(5'd23, 6'd59, 6'd59);
    send_time(5'd10, 6'd15, 6'd0);
    send_time(5'd6, 6'd27, 6'd29);
    send_time(5'd6, 6'd27, 6'd30);
    wait_idle();
    apply_config(1'b0, 2'd1, 1'b0);
    for (int k = 0; k < 12; k++) send_time(5'(2 * k), 6'(5 * k), 6'd0);
    wait_idle();
    apply_config(1'b1, 2'd2, 1'b1);
    send_time(5'd1, 6'd15, 6'd0);
    send_time(5'd11, 6'd20, 6'd0);
    send_time(5'd12, 6'd40, 6'd0);
    send_time(5'd0, 6'd45, 6'd0);
    wait_idle();
  endtask

  task automatic test_random(input int unsigned send_pct, input int unsigned recv_pct);
    logic [4:0] h;
    logic [5:0] m;
    logic [5:0] s;
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
    for (int blk = 0; blk < 6; blk++) begin
      wait_idle();
      apply_config(1'($urandom_range(1)), 2'($urandom_range(3)), 1'($urandom_range(1)));
      for (int n = 0; n < 10; n++) begin
        if ($urandom_range(29) == 0) wait_idle();
        if ($urandom_range(4) == 0) begin
          h = 5'($urandom_range(31));
          m = 6'($urandom_range(63));
          s = 6'($urandom_range(63));
        end else begin
          h = 5'($urandom_range(23));
          m = 6'($urandom_range(59));
          s = 6'($urandom_range(59));
        end
        send_time(h, m, s);
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(7, 79);
    test_random(79, 7);
    test_random(0, 0);
    wait_idle();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d times of day under %0d register settings, both dialects,",
             times_sent, settings_used);
    $display("and compared %0d word beats with %0d mismatches.", words_checked, mismatches);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
